FILE: design/x86ild_pkg.sv
// Package with the opcode classes, decode record and length helpers of the length decoder.
`default_nettype none
package x86ild_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned LenW   = 4;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned ClassW = 5;

  localparam logic [AddrW-1:0] RegionStartReset = 32'h0000_7C00;

  typedef enum logic [ClassW-1:0] {
    CLS_DB         = 5'd0,
    CLS_SINGLE     = 5'd1,
    CLS_SHORT_BR   = 5'd2,
    CLS_PUSH_IMM32 = 5'd3,
    CLS_PUSH_IMM8  = 5'd4,
    CLS_CALL_REL32 = 5'd5,
    CLS_JMP_REL32  = 5'd6,
    CLS_INT        = 5'd7,
    CLS_ALU_IMM    = 5'd8,
    CLS_INC        = 5'd9,
    CLS_DEC        = 5'd10,
    CLS_MOV_R8_IMM = 5'd11,
    CLS_MOV_R32_IMM = 5'd12,
    CLS_MOV_MODRM  = 5'd13,
    CLS_TWO_BYTE   = 5'd14,
    CLS_MOV_MOFFS  = 5'd15,
    CLS_MOV_RM_IMM = 5'd16
  } instr_class_e;

  typedef struct packed {
    instr_class_e           cls;
    logic [IdxW-1:0]        idx;
    logic [LenW-1:0]        len;
  } op_info_t;

  localparam logic [7:0] OpTwoByte  = 8'h0F;
  localparam logic [7:0] OpPush32   = 8'h68;
  localparam logic [7:0] OpPush8    = 8'h6A;
  localparam logic [7:0] OpCall     = 8'hE8;
  localparam logic [7:0] OpJmp      = 8'hE9;
  localparam logic [7:0] OpJmpShort = 8'hEB;
  localparam logic [7:0] OpInt      = 8'hCD;
  localparam logic [7:0] OpMovRmImm8  = 8'hC6;
  localparam logic [7:0] OpMovRmImm32 = 8'hC7;
  localparam logic [7:0] OpShld     = 8'hA4;
  localparam logic [7:0] OpShldCl   = 8'hA5;
  localparam logic [7:0] AluMask    = 8'hFC;
  localparam logic [7:0] AluBase    = 8'h80;

  // Extra displacement bytes implied by the mod field of a ModRM byte.
  function automatic logic [LenW-1:0] mod_extra(input logic [7:0] modrm);
    logic [LenW-1:0] extra;
    begin
      case (modrm[7:6])
        2'd1:    extra = LenW'(1);
        2'd2:    extra = LenW'(2);
        default: extra = '0;
      endcase
      return extra;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/x86ild_classify.sv
// Opcode classifier: class, list position and base length of a first byte.
`default_nettype none
module x86ild_classify (
  input  logic [7:0]          op_i,
  output x86ild_pkg::op_info_t info_o
);
  import x86ild_pkg::*;

  always_comb begin
    info_o.cls = CLS_DB;
    info_o.idx = '0;
    info_o.len = LenW'(1);
    case (op_i) inside
      [8'h50:8'h5F], 8'h60, 8'h61, 8'h90, 8'h9C, 8'h9D, 8'hC3, 8'hCB, 8'hCC, 8'hCF,
      8'hF4, 8'hF5, [8'hF8:8'hFD]: begin
        info_o.cls = CLS_SINGLE;
        info_o.len = LenW'(1);
        case (op_i) inside
          [8'h50:8'h5F]: info_o.idx = IdxW'(op_i[3:0]);
          8'h60:         info_o.idx = IdxW'(16);
          8'h61:         info_o.idx = IdxW'(17);
          8'h90:         info_o.idx = IdxW'(18);
          8'h9C:         info_o.idx = IdxW'(19);
          8'h9D:         info_o.idx = IdxW'(20);
          8'hC3:         info_o.idx = IdxW'(21);
          8'hCB:         info_o.idx = IdxW'(22);
          8'hCC:         info_o.idx = IdxW'(23);
          8'hCF:         info_o.idx = IdxW'(24);
          8'hF4:         info_o.idx = IdxW'(25);
          8'hF5:         info_o.idx = IdxW'(26);
          default:       info_o.idx = IdxW'(op_i[2:0]) + IdxW'(27);
        endcase
      end
      [8'h70:8'h7F], [8'hE0:8'hE3], OpJmpShort: begin
        info_o.cls = CLS_SHORT_BR;
        info_o.len = LenW'(2);
        case (op_i) inside
          [8'h70:8'h7F]: info_o.idx = IdxW'(op_i[3:0]);
          [8'hE0:8'hE3]: info_o.idx = IdxW'(op_i[1:0]) + IdxW'(16);
          default:       info_o.idx = IdxW'(20);
        endcase
      end
      OpPush32: begin
        info_o.cls = CLS_PUSH_IMM32;
        info_o.len = LenW'(5);
      end
      OpPush8: begin
        info_o.cls = CLS_PUSH_IMM8;
        info_o.len = LenW'(2);
      end
      OpCall: begin
        info_o.cls = CLS_CALL_REL32;
        info_o.len = LenW'(5);
      end
      OpJmp: begin
        info_o.cls = CLS_JMP_REL32;
        info_o.len = LenW'(5);
      end
      OpInt: begin
        info_o.cls = CLS_INT;
        info_o.len = LenW'(2);
      end
      [8'h80:8'h83]: begin
        info_o.cls = CLS_ALU_IMM;
        info_o.len = op_i[0] ? LenW'(6) : LenW'(3);
      end
      [8'h40:8'h47]: info_o.cls = CLS_INC;
      [8'h48:8'h4F]: info_o.cls = CLS_DEC;
      [8'hB0:8'hB7]: begin
        info_o.cls = CLS_MOV_R8_IMM;
        info_o.len = LenW'(2);
      end
      [8'hB8:8'hBF]: begin
        info_o.cls = CLS_MOV_R32_IMM;
        info_o.len = LenW'(5);
      end
      [8'h88:8'h8B]: begin
        info_o.cls = CLS_MOV_MODRM;
        info_o.len = LenW'(2);
      end
      OpTwoByte: begin
        info_o.cls = CLS_TWO_BYTE;
        info_o.len = LenW'(2);
      end
      8'hA0, 8'hA2: begin
        info_o.cls = CLS_MOV_MOFFS;
        info_o.len = LenW'(2);
      end
      8'hA1, 8'hA3: begin
        info_o.cls = CLS_MOV_MOFFS;
        info_o.len = LenW'(5);
      end
      OpMovRmImm8, OpMovRmImm32: begin
        info_o.cls = CLS_MOV_RM_IMM;
        info_o.len = LenW'(3);
      end
      default: begin
        info_o.cls = CLS_DB;
        info_o.len = LenW'(1);
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/x86_instruction_length_decoder_top.sv
// Top level of the streaming instruction length decoder with its result register.
`default_nettype none
// One code byte is taken per request, and a new request can be taken in every cycle. An
// instruction's result appears in the result register in the cycle after the request that
// carries its last byte (or the byte marked as region end); the single result register is
// what lies between the two, and input stalls only while that register holds a result
// that is itself stalled. No clearing pass follows reset.
module x86_instruction_length_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        region_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] instr_address_o,
  output logic [3:0]  instr_length_o,
  output logic [7:0]  opcode_value_o,
  output logic [4:0]  instr_class_o,
  output logic [5:0]  list_index_o,
  output logic        target_valid_o,
  output logic [31:0] branch_target_o,
  output logic [7:0]  int_vector_o,
  output logic        clipped_o
);
  import x86ild_pkg::*;

  logic [AddrW-1:0] region_start_q;
  logic [AddrW-1:0] next_addr_q, next_addr_d;
  logic             fresh_q, fresh_d;
  logic [AddrW-1:0] instr_start_q;
  logic [LenW-1:0]  held_q, held_d;
  logic [LenW-1:0]  need_q, need_d;
  logic [7:0]       first_q;
  logic [7:0]       second_q;
  logic [AddrW-1:0] disp_q;
  logic             out_valid_q, out_valid_d;

  logic             accept;
  logic [AddrW-1:0] addr_cur, start_cur, disp_cur, offset, target;
  logic [7:0]       op_cur, second_cur;
  logic [LenW-1:0]  need_cur, held_new, tgt_len;
  logic             done, clip, is_short, is_rel32;
  op_info_t         info;

  x86ild_classify u_classify (
    .op_i   (op_cur),
    .info_o (info)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign addr_cur   = fresh_q ? region_start_q : next_addr_q;
  assign start_cur  = (held_q == '0) ? addr_cur : instr_start_q;
  assign op_cur     = (held_q == '0) ? code_byte_i : first_q;
  assign second_cur = (held_q == LenW'(1)) ? code_byte_i : second_q;
  assign held_new   = held_q + LenW'(1);

  always_comb begin
    need_cur = need_q;
    case (held_q)
      LenW'(0): need_cur = info.len;
      LenW'(1): begin
        if (first_q inside {[8'h88:8'h8B]}) begin
          need_cur = LenW'(2) + mod_extra(code_byte_i);
        end else if (first_q == OpTwoByte) begin
          if (code_byte_i inside {[8'h80:8'h8F], OpShld, OpShldCl}) begin
            need_cur = LenW'(3);
          end
        end else if (first_q == OpMovRmImm8 || first_q == OpMovRmImm32) begin
          need_cur = LenW'(3) + mod_extra(code_byte_i)
                   + ((first_q == OpMovRmImm32) ? LenW'(4) : LenW'(0));
        end
      end
      LenW'(2): begin
        if (first_q == OpTwoByte) begin
          need_cur = LenW'(3) + mod_extra(code_byte_i);
        end
      end
      default: need_cur = need_q;
    endcase
  end

  always_comb begin
    disp_cur = disp_q;
    case (held_q)
      LenW'(0): disp_cur = '0;
      LenW'(1): disp_cur = disp_q | {24'd0, code_byte_i};
      LenW'(2): disp_cur = disp_q | {16'd0, code_byte_i, 8'd0};
      LenW'(3): disp_cur = disp_q | {8'd0, code_byte_i, 16'd0};
      LenW'(4): disp_cur = disp_q | {code_byte_i, 24'd0};
      default:  disp_cur = disp_q;
    endcase
  end

  assign clip     = held_new < need_cur;
  assign done     = !clip || region_end_i;
  assign is_short = (op_cur inside {[8'h70:8'h7F]}) || (op_cur == OpJmpShort);
  assign is_rel32 = (op_cur == OpCall) || (op_cur == OpJmp);
  assign offset   = is_short ? {{24{second_cur[7]}}, second_cur} : disp_cur;
  assign tgt_len  = is_short ? LenW'(2) : LenW'(5);
  assign target   = start_cur + AddrW'(tgt_len) + offset;

  always_comb begin
    next_addr_d = next_addr_q;
    fresh_d     = fresh_q;
    held_d      = held_q;
    need_d      = need_q;
    if (accept) begin
      next_addr_d = addr_cur + AddrW'(1);
      fresh_d     = region_end_i;
      held_d      = done ? '0 : held_new;
      need_d      = done ? '0 : need_cur;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (accept && done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= RegionStartReset;
      next_addr_q    <= '0;
      fresh_q        <= 1'b1;
      held_q         <= '0;
      need_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        region_start_q <= cfg_wdata_i;
      end
      next_addr_q <= next_addr_d;
      fresh_q     <= fresh_d;
      held_q      <= held_d;
      need_q      <= need_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      disp_q <= disp_cur;
      if (held_q == '0) begin
        instr_start_q <= addr_cur;
        first_q       <= code_byte_i;
      end
      if (held_q == LenW'(1)) begin
        second_q <= code_byte_i;
      end
    end
    if (accept && done) begin
      instr_address_o <= start_cur;
      instr_length_o  <= held_new;
      opcode_value_o  <= op_cur;
      instr_class_o   <= info.cls;
      list_index_o    <= info.idx;
      target_valid_o  <= !clip && (is_short || is_rel32);
      branch_target_o <= (!clip && (is_short || is_rel32)) ? target : '0;
      int_vector_o    <= (!clip && op_cur == OpInt) ? second_cur : 8'd0;
      clipped_o       <= clip;
    end
  end

  assign out_valid_o = out_valid_q;

  // An instruction still being collected always needs more bytes than it holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != '0 |-> held_q < need_q)
    else $error("partial instruction already holds its full length");

  // A region end always closes the instruction and restarts addressing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && region_end_i |=> held_q == '0 && fresh_q && out_valid_q)
    else $error("region end did not close the instruction");

  // Clipped instructions carry neither a branch target nor an interrupt vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> !target_valid_o && int_vector_o == 8'd0)
    else $error("clipped instruction reports a target or vector");

  // Length never exceeds the longest form the rules allow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> instr_length_o != '0 && instr_length_o <= LenW'(9))
    else $error("instruction length out of range");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the streaming x86 instruction length decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import x86ild_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 3;
  localparam int PhaseBytes    = 175;
  localparam int MaxReports    = 50;

  localparam logic [7:0] OpNop         = 8'h90;
  localparam logic [7:0] OpHlt         = 8'hF4;
  localparam logic [7:0] OpJo          = 8'h70;
  localparam logic [7:0] JccFirst      = 8'h70;
  localparam logic [7:0] JccLast       = 8'h7F;
  localparam logic [7:0] IncFirst      = 8'h40;
  localparam logic [7:0] IncLast       = 8'h47;
  localparam logic [7:0] DecFirst      = 8'h48;
  localparam logic [7:0] DecLast       = 8'h4F;
  localparam logic [7:0] MovR8First    = 8'hB0;
  localparam logic [7:0] MovR8Last     = 8'hB7;
  localparam logic [7:0] MovR32First   = 8'hB8;
  localparam logic [7:0] MovR32Last    = 8'hBF;
  localparam logic [7:0] MovModrmFirst = 8'h88;
  localparam logic [7:0] MovModrmLast  = 8'h8B;
  localparam logic [7:0] MoffsFirst    = 8'hA0;
  localparam logic [7:0] MoffsLast     = 8'hA3;
  localparam logic [7:0] Jcc32First    = 8'h80;
  localparam logic [7:0] Jcc32Last     = 8'h8F;
  localparam logic [7:0] AluImm8Alt    = 8'h82;

  localparam logic [33*8-1:0] SingleOps = {
    8'hFD, 8'hFC, 8'hFB, 8'hFA, 8'hF9, 8'hF8, 8'hF5, 8'hF4, 8'hCF, 8'hCC, 8'hCB,
    8'hC3, 8'h9D, 8'h9C, 8'h90, 8'h61, 8'h60, 8'h5F, 8'h5E, 8'h5D, 8'h5C, 8'h5B,
    8'h5A, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55, 8'h54, 8'h53, 8'h52, 8'h51, 8'h50
  };
  localparam logic [21*8-1:0] ShortBranchOps = {
    8'hEB, 8'hE3, 8'hE2, 8'hE1, 8'hE0, 8'h7F, 8'h7E, 8'h7D, 8'h7C, 8'h7B, 8'h7A,
    8'h79, 8'h78, 8'h77, 8'h76, 8'h75, 8'h74, 8'h73, 8'h72, 8'h71, 8'h70
  };

  typedef struct packed {
    logic [31:0]  addr;
    logic [3:0]   len;
    logic [7:0]   op;
    instr_class_e cls;
    logic [5:0]   idx;
    logic         tv;
    logic [31:0]  tgt;
    logic [7:0]   vec;
    logic         clip;
  } instr_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  code_byte_i;
  logic        region_end_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] instr_address_o;
  logic [3:0]  instr_length_o;
  logic [7:0]  opcode_value_o;
  logic [4:0]  instr_class_o;
  logic [5:0]  list_index_o;
  logic        target_valid_o;
  logic [31:0] branch_target_o;
  logic [7:0]  int_vector_o;
  logic        clipped_o;

  x86_instruction_length_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_byte_i     (code_byte_i),
    .region_end_i    (region_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .instr_address_o (instr_address_o),
    .instr_length_o  (instr_length_o),
    .opcode_value_o  (opcode_value_o),
    .instr_class_o   (instr_class_o),
    .list_index_o    (list_index_o),
    .target_valid_o  (target_valid_o),
    .branch_target_o (branch_target_o),
    .int_vector_o    (int_vector_o),
    .clipped_o       (clipped_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decoder state as the testbench tracks it.
  logic [31:0] region_start_cfg = RegionStartReset;
  logic [31:0] next_addr        = RegionStartReset;
  logic        region_open      = 1'b0;
  logic [31:0] cur_start        = '0;
  logic [3:0]  held_bytes       = '0;
  logic [3:0]  need_bytes       = '0;
  logic [7:0]  op_byte          = '0;
  logic [7:0]  modrm_byte       = '0;
  logic [31:0] imm_bytes        = '0;

  instr_rec_t expected_instrs[$];

  int   mismatches    = 0;
  int   bytes_sent    = 0;
  int   instrs_seen   = 0;
  int   clipped_seen  = 0;
  int   targets_seen  = 0;
  int   config_writes = 0;
  int   quiet_cycles  = 0;
  int   out_hold      = 0;
  bit   send_busy     = 1'b1;
  bit   recv_busy     = 1'b1;

  function automatic int draw_wait(input bit busy);
    return busy ? int'($urandom_range(0, 10)) : 0;
  endfunction

  function automatic logic [3:0] disp_bytes(input logic [7:0] modrm);
    case (modrm[7:6])
      2'd1:    return 4'd1;
      2'd2:    return 4'd2;
      default: return 4'd0;
    endcase
  endfunction

  function automatic void classify_opcode(input logic [7:0] op, output instr_class_e cls,
                                          output logic [3:0] len, output logic [5:0] idx);
    int i;
    cls = CLS_DB;
    len = 4'd1;
    idx = '0;
    for (i = 0; i < 33; i++) begin
      if (SingleOps[i*8 +: 8] == op) begin
        cls = CLS_SINGLE;
        idx = 6'(i);
        return;
      end
    end
    for (i = 0; i < 21; i++) begin
      if (ShortBranchOps[i*8 +: 8] == op) begin
        cls = CLS_SHORT_BR;
        idx = 6'(i);
        len = 4'd2;
        return;
      end
    end
    if (op == OpPush32) begin
      cls = CLS_PUSH_IMM32;
      len = 4'd5;
    end else if (op == OpPush8) begin
      cls = CLS_PUSH_IMM8;
      len = 4'd2;
    end else if (op == OpCall) begin
      cls = CLS_CALL_REL32;
      len = 4'd5;
    end else if (op == OpJmp) begin
      cls = CLS_JMP_REL32;
      len = 4'd5;
    end else if (op == OpInt) begin
      cls = CLS_INT;
      len = 4'd2;
    end else if ((op & AluMask) == AluBase) begin
      cls = CLS_ALU_IMM;
      len = (op == AluBase || op == AluImm8Alt) ? 4'd3 : 4'd6;
    end else if (op >= IncFirst && op <= IncLast) begin
      cls = CLS_INC;
    end else if (op >= DecFirst && op <= DecLast) begin
      cls = CLS_DEC;
    end else if (op >= MovR8First && op <= MovR8Last) begin
      cls = CLS_MOV_R8_IMM;
      len = 4'd2;
    end else if (op >= MovR32First && op <= MovR32Last) begin
      cls = CLS_MOV_R32_IMM;
      len = 4'd5;
    end else if (op >= MovModrmFirst && op <= MovModrmLast) begin
      cls = CLS_MOV_MODRM;
      len = 4'd2;
    end else if (op == OpTwoByte) begin
      cls = CLS_TWO_BYTE;
      len = 4'd2;
    end else if (op >= MoffsFirst && op <= MoffsLast) begin
      cls = CLS_MOV_MOFFS;
      len = op[0] ? 4'd5 : 4'd2;
    end else if (op == OpMovRmImm8 || op == OpMovRmImm32) begin
      cls = CLS_MOV_RM_IMM;
      len = 4'd3;
    end
  endfunction

  // Advances the tracked state by one accepted code byte and queues any finished instruction.
  function automatic void take_code_byte(input logic [7:0] b, input logic last);
    instr_rec_t   rec;
    instr_class_e cls;
    logic [3:0]   base_len;
    logic [5:0]   idx;
    if (!region_open) begin
      next_addr = region_start_cfg;
      region_open = 1'b1;
    end
    if (held_bytes == 4'd0) begin
      cur_start = next_addr;
      op_byte = b;
      imm_bytes = '0;
      classify_opcode(b, cls, need_bytes, idx);
    end else begin
      if (held_bytes == 4'd1) begin
        modrm_byte = b;
        if (op_byte >= MovModrmFirst && op_byte <= MovModrmLast) begin
          need_bytes = 4'd2 + disp_bytes(b);
        end else if (op_byte == OpTwoByte) begin
          if ((b >= Jcc32First && b <= Jcc32Last) || b == OpShld || b == OpShldCl) begin
            need_bytes = 4'd3;
          end
        end else if (op_byte == OpMovRmImm8 || op_byte == OpMovRmImm32) begin
          need_bytes = 4'd3 + disp_bytes(b) + ((op_byte == OpMovRmImm32) ? 4'd4 : 4'd0);
        end
      end else if (held_bytes == 4'd2 && op_byte == OpTwoByte) begin
        need_bytes = 4'd3 + disp_bytes(b);
      end
      if (held_bytes <= 4'd4) begin
        imm_bytes = imm_bytes | ({24'b0, b} << (8 * (int'(held_bytes) - 1)));
      end
    end
    held_bytes = held_bytes + 4'd1;
    next_addr = next_addr + 32'd1;
    if (held_bytes < need_bytes && !last) begin
      return;
    end
    classify_opcode(op_byte, cls, base_len, idx);
    rec.addr = cur_start;
    rec.len  = held_bytes;
    rec.op   = op_byte;
    rec.cls  = cls;
    rec.idx  = idx;
    rec.clip = held_bytes < need_bytes;
    rec.tv   = 1'b0;
    rec.tgt  = '0;
    rec.vec  = '0;
    if (!rec.clip) begin
      if ((op_byte >= JccFirst && op_byte <= JccLast) || op_byte == OpJmpShort) begin
        rec.tv  = 1'b1;
        rec.tgt = cur_start + 32'd2 + {{24{modrm_byte[7]}}, modrm_byte};
      end else if (op_byte == OpCall || op_byte == OpJmp) begin
        rec.tv  = 1'b1;
        rec.tgt = cur_start + 32'd5 + imm_bytes;
      end else if (op_byte == OpInt) begin
        rec.vec = modrm_byte;
      end
    end
    expected_instrs.push_back(rec);
    held_bytes = '0;
    need_bytes = '0;
    if (last) begin
      region_open = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    instr_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_hold = draw_wait(recv_busy);
      if (expected_instrs.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("%0t: unexpected result, expected none, actual address %0h", $time,
                   instr_address_o);
        end
        mismatches++;
      end else begin
        want = expected_instrs.pop_front();
        instrs_seen++;
        if (want.clip) clipped_seen++;
        if (want.tv) targets_seen++;
        if (instrs_seen % 50 == 0) recv_busy = $urandom_range(0, 2) != 0;
        check_field("instr_address", want.addr, instr_address_o);
        check_field("instr_length", 32'(want.len), 32'(instr_length_o));
        check_field("opcode_value", 32'(want.op), 32'(opcode_value_o));
        check_field("instr_class", 32'(want.cls), 32'(instr_class_o));
        check_field("list_index", 32'(want.idx), 32'(list_index_o));
        check_field("target_valid", 32'(want.tv), 32'(target_valid_o));
        check_field("branch_target", want.tgt, branch_target_o);
        check_field("int_vector", 32'(want.vec), 32'(int_vector_o));
        check_field("clipped", 32'(want.clip), 32'(clipped_o));
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = (out_hold != 0);
    if (out_hold != 0) out_hold--;
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait(send_busy);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    code_byte_i  = b;
    region_end_i = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    take_code_byte(b, last);
    bytes_sent++;
    if (bytes_sent % 60 == 0) send_busy = $urandom_range(0, 2) != 0;
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_instrs.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_region_start(input logic [31:0] value);
    wait_results_done();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    region_start_cfg = value;
    config_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_after_reset();
    send_byte(OpNop, 1'b0);
    send_byte(OpJmpShort, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(OpInt, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(OpCall, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_address_wrap();
    write_region_start(32'hFFFF_FFFF);
    send_byte(OpJmp, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(OpTwoByte, 1'b0);
    send_byte(OpShld, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(DecFirst, 1'b1);
  endtask

  task automatic test_clipped_instructions();
    write_region_start(32'h0000_0000);
    send_byte(OpMovRmImm32, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(OpInt, 1'b1);
  endtask

  task automatic test_midregion_config();
    send_byte(OpJo, 1'b0);
    send_byte(8'h7F, 1'b0);
    write_region_start(32'h1234_5678);
    send_byte(OpHlt, 1'b1);
    send_byte(OpNop, 1'b1);
  endtask

  task automatic send_random_instr();
    logic [7:0] op;
    logic [7:0] nxt;
    int         pick;
    int         end_at;
    int         pos;
    int         region_mode;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       op = SingleOps[$urandom_range(0, 32)*8 +: 8];
      1, 15:   op = ShortBranchOps[$urandom_range(0, 20)*8 +: 8];
      2:       op = 8'($urandom_range(0, 255));
      3:       op = $urandom_range(0, 1) ? OpPush32 : OpPush8;
      4:       op = $urandom_range(0, 1) ? OpCall : OpJmp;
      5:       op = OpInt;
      6:       op = AluBase | 8'($urandom_range(0, 3));
      7:       op = IncFirst + 8'($urandom_range(0, 15));
      8:       op = MovR8First + 8'($urandom_range(0, 15));
      9, 10:   op = MovModrmFirst + 8'($urandom_range(0, 3));
      11, 12:  op = OpTwoByte;
      13:      op = MoffsFirst + 8'($urandom_range(0, 3));
      default: op = $urandom_range(0, 1) ? OpMovRmImm8 : OpMovRmImm32;
    endcase
    region_mode = $urandom_range(0, 19);
    end_at = (region_mode == 0) ? int'($urandom_range(1, 3)) : 0;
    pos = 1;
    send_byte(op, end_at == 1);
    while (held_bytes != 4'd0) begin
      pos++;
      nxt = 8'($urandom_range(0, 255));
      if (pos == 2 && op == OpTwoByte && $urandom_range(0, 1)) begin
        if ($urandom_range(0, 3) == 0) begin
          nxt = $urandom_range(0, 1) ? OpShld : OpShldCl;
        end else begin
          nxt = Jcc32First + 8'($urandom_range(0, 15));
        end
      end
      send_byte(nxt, end_at == pos);
    end
    if (region_mode == 1) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_stream();
    int          phase;
    int          first;
    bit          paused;
    logic [31:0] start_value;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       start_value = 32'h0000_0000;
        1:       start_value = 32'hFFFF_FFF8;
        2:       start_value = $urandom();
        default: start_value = RegionStartReset;
      endcase
      write_region_start(start_value);
      first = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - first < PhaseBytes) begin
        send_random_instr();
        if (!paused && bytes_sent - first >= PhaseBytes / 2) begin
          wait_results_done();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    code_byte_i  = '0;
    region_end_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_address_wrap();
    test_clipped_instructions();
    test_midregion_config();
    test_random_stream();

    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d code bytes, checked %0d instructions (%0d clipped, %0d with targets)",
             bytes_sent, instrs_seen, clipped_seen, targets_seen);
    $display("over %0d region start settings, with address wrap and random stalls on both sides.",
             config_writes + 1);
    if (mismatches == 0 && expected_instrs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
